// ----- rtl/hrf_pkg.sv -----
// Shared types, constants and character tables for the HTTP response framer.
// No dependencies; imported by hrf_scan, http_response_framer, hrf_checker and tb.
`default_nettype none

package hrf_pkg;

  localparam int MAX_LENGTH_DIGITS = 6;
  localparam int MIN_MESSAGE_BYTES = 20;
  localparam int COUNT_W           = 21;
  localparam int LEN_W             = 20;
  localparam int LABEL_LEN         = 16;
  localparam int PREFIX_LEN        = 4;
  localparam int DIGIT_W           = 3;
  localparam int LABEL_W           = 5;
  localparam int BUFSIZE_RESET     = 8192;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_C     = 8'h43;

  typedef enum logic [1:0] {
    STATUS_INCOMPLETE = 2'd0,
    STATUS_COMPLETE   = 2'd1,
    STATUS_NOT_HTTP   = 2'd2,
    STATUS_BAD_LENGTH = 2'd3
  } status_t;

  typedef struct packed {
    logic [COUNT_W-1:0] byte_count;
    logic [1:0]         terminator_match;
    logic               prefix_ok;
    logic [LABEL_W-1:0] label_match;
    logic               in_length_value;
    logic [DIGIT_W-1:0] digit_chars;
    logic               digits_stopped;
    logic [LEN_W-1:0]   length_value;
    logic               header_done;
    logic [COUNT_W-1:0] header_bytes;
  } msg_state_t;

  localparam msg_state_t MSG_RESET = '{
    byte_count:       '0,
    terminator_match: '0,
    prefix_ok:        1'b1,
    label_match:      '0,
    in_length_value:  1'b0,
    digit_chars:      '0,
    digits_stopped:   1'b0,
    length_value:     '0,
    header_done:      1'b0,
    header_bytes:     '0
  };

  // "Content-Length: "
  function automatic logic [7:0] label_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = " ";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] term_char(input logic [1:0] idx);
    return idx[0] ? CHAR_LF : CHAR_CR;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = "H";
      2'd1:    c = "T";
      2'd2:    c = "T";
      default: c = "P";
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/http_response_framer.sv -----
// Top level: HTTP response framer with Content-Length, one verdict per byte.
// Depends on hrf_pkg and hrf_scan.
//
//   channel   signals                                       dir
//   in        in_valid, in_ready, data_byte                 sink
//   out       out_valid, out_ready, status, header_length,  source
//             body_length
//   cfg       cfg_valid, cfg_ready, cfg_data (buffer_size)  sink
//
// One byte per cycle unless the result channel stalls; each accepted byte yields its verdict in the cycle after.
// The message state registers and the single result register set the rate.
// in_ready drops only while a result is held and out_ready is low.
// Reset (rst, synchronous) clears message state and errors; buffer_size 8192.
// cfg_ready is always high.
`default_nettype none

module http_response_framer
  import hrf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [COUNT_W-1:0] header_length,
  output logic [LEN_W-1:0]   body_length,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  msg_state_t         msg;
  msg_state_t         msg_scan;
  msg_state_t         msg_next;
  status_t            sticky_error;
  status_t            sticky_error_next;
  logic [COUNT_W-1:0] buffer_size;
  logic               accept;
  logic               complete;
  logic [COUNT_W:0]   total;
  status_t            res_status;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  hrf_scan u_scan (
    .cur       (msg),
    .data_byte (data_byte),
    .nxt       (msg_scan)
  );

  assign total = {1'b0, msg_scan.header_bytes} + (COUNT_W+1)'(msg_scan.length_value);

  always_comb begin
    msg_next          = msg;
    sticky_error_next = sticky_error;
    complete          = 1'b0;
    if (sticky_error == STATUS_INCOMPLETE) begin
      msg_next = msg_scan;
      if (msg_scan.header_done &&
          msg_scan.byte_count >= COUNT_W'(MIN_MESSAGE_BYTES)) begin
        if (!msg_scan.prefix_ok) begin
          sticky_error_next = STATUS_NOT_HTTP;
        end else if (msg_scan.digit_chars > DIGIT_W'(MAX_LENGTH_DIGITS) ||
                     total > {1'b0, buffer_size}) begin
          sticky_error_next = STATUS_BAD_LENGTH;
        end else if (total <= {1'b0, msg_scan.byte_count}) begin
          complete = 1'b1;
          msg_next = MSG_RESET;
        end
      end
    end
    if (sticky_error_next != STATUS_INCOMPLETE) begin
      res_status = sticky_error_next;
    end else if (complete) begin
      res_status = STATUS_COMPLETE;
    end else begin
      res_status = STATUS_INCOMPLETE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg          <= MSG_RESET;
      sticky_error <= STATUS_INCOMPLETE;
      buffer_size  <= COUNT_W'(BUFSIZE_RESET);
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        msg          <= msg_next;
        sticky_error <= sticky_error_next;
      end
      if (cfg_valid && cfg_ready) begin
        buffer_size <= cfg_data;
      end
      out_valid <= accept || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= res_status;
      header_length <= complete ? msg_scan.header_bytes : '0;
      body_length   <= complete ? msg_scan.length_value : '0;
    end
  end

`ifndef SYNTHESIS
  a_lengths_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_COMPLETE |-> header_length == '0 && body_length == '0)
    else $error("lengths non-zero on a non-complete result");

  a_header_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_COMPLETE |-> header_length >= COUNT_W'(4))
    else $error("complete message with header shorter than blank line");

  a_sticky_holds: assert property (@(posedge clk) disable iff (rst)
    sticky_error != STATUS_INCOMPLETE |=> sticky_error == $past(sticky_error))
    else $error("sticky error changed without reset");

  a_sticky_reported: assert property (@(posedge clk) disable iff (rst)
    accept && sticky_error != STATUS_INCOMPLETE |=> status == $past(sticky_error))
    else $error("sticky error not reported");

  a_error_resets_no_msg: assert property (@(posedge clk) disable iff (rst)
    sticky_error != STATUS_INCOMPLETE |=> msg == $past(msg))
    else $error("message state moved after an error");
`endif

endmodule

`default_nettype wire

// ----- rtl/hrf_scan.sv -----
// Per-byte header scanner: prefix check, label search, length digits, blank line.
// Depends on hrf_pkg.
`default_nettype none

module hrf_scan
  import hrf_pkg::*;
(
  input  msg_state_t cur,
  input  logic [7:0] data_byte,
  output msg_state_t nxt
);

  logic               is_digit;
  logic [DIGIT_W-1:0] dchars;
  logic [LABEL_W-1:0] lm;
  logic [LEN_W+3:0]   times_ten;

  assign is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
  assign times_ten = {cur.length_value, 3'b000} + {2'b00, cur.length_value, 1'b0}
                     + (LEN_W+4)'(data_byte - CHAR_ZERO);

  always_comb begin
    nxt    = cur;
    dchars = cur.digit_chars;
    lm     = cur.label_match;

    if (cur.byte_count != COUNT_MAX) begin
      nxt.byte_count = cur.byte_count + COUNT_W'(1);
    end

    if (!cur.header_done) begin
      if (cur.byte_count < COUNT_W'(PREFIX_LEN) &&
          data_byte != prefix_char(cur.byte_count[1:0])) begin
        nxt.prefix_ok = 1'b0;
      end

      if (cur.in_length_value) begin
        if (data_byte == CHAR_CR) begin
          nxt.in_length_value = 1'b0;
        end else begin
          if (dchars == '0 && data_byte == CHAR_MINUS) begin
            dchars = DIGIT_W'(MAX_LENGTH_DIGITS + 1);
          end
          if (dchars < DIGIT_W'(MAX_LENGTH_DIGITS)) begin
            if (!cur.digits_stopped && is_digit) begin
              nxt.length_value = times_ten[LEN_W-1:0];
            end else begin
              nxt.digits_stopped = 1'b1;
            end
          end
          if (dchars <= DIGIT_W'(MAX_LENGTH_DIGITS)) begin
            dchars = dchars + DIGIT_W'(1);
          end
          nxt.digit_chars = dchars;
        end
      end

      if (cur.label_match < LABEL_W'(LABEL_LEN)) begin
        if (data_byte == label_char(cur.label_match[3:0])) begin
          lm = cur.label_match + LABEL_W'(1);
        end else begin
          lm = (data_byte == CHAR_C) ? LABEL_W'(1) : '0;
        end
        nxt.label_match = lm;
        if (lm == LABEL_W'(LABEL_LEN)) begin
          nxt.in_length_value = 1'b1;
        end
      end

      if (data_byte == term_char(cur.terminator_match)) begin
        if (cur.terminator_match == 2'd3) begin
          nxt.header_done      = 1'b1;
          nxt.header_bytes     = nxt.byte_count;
          nxt.terminator_match = 2'd0;
        end else begin
          nxt.terminator_match = cur.terminator_match + 2'd1;
        end
      end else begin
        nxt.terminator_match = (data_byte == CHAR_CR) ? 2'd1 : 2'd0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- bench/hrf_checker.sv -----
// Scoreboard for http_response_framer. It predicts one verdict per accepted
// byte, queues it and compares it with every result transaction.
// Depends on hrf_pkg; instantiated by tb beside the block.
module hrf_checker
  import hrf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         status,
  input  logic [COUNT_W-1:0] header_length,
  input  logic [LEN_W-1:0]   body_length,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data,
  output int                 mismatches,
  output int                 pending,
  output int                 bytes_seen,
  output int                 messages_framed,
  output int                 error_verdicts
);

  localparam logic [127:0] LABEL_TEXT  = "Content-Length: ";
  localparam logic [31:0]  PREFIX_TEXT = "HTTP";
  localparam logic [31:0]  TERM_TEXT   = {CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF};

  typedef struct packed {
    logic [COUNT_W-1:0] seen;
    logic [1:0]         crlf_pos;
    logic               http_ok;
    logic [LABEL_W-1:0] label_pos;
    logic               in_value;
    logic [DIGIT_W-1:0] value_chars;
    logic               value_end;
    logic [LEN_W-1:0]   value;
    logic               head_done;
    logic [COUNT_W-1:0] head_len;
  } frame_t;

  typedef struct packed {
    status_t            st;
    logic [COUNT_W-1:0] hlen;
    logic [LEN_W-1:0]   blen;
  } verdict_t;

  frame_t             frm;
  status_t            held_error;
  logic [COUNT_W-1:0] capacity;
  verdict_t           verdicts_due[$];
  verdict_t           want;

  function automatic frame_t fresh_frame();
    frame_t f;
    f = '0;
    f.http_ok = 1'b1;
    return f;
  endfunction

  function automatic verdict_t frame_verdict(input logic [7:0] b);
    verdict_t           v;
    logic [COUNT_W-1:0] pos;
    logic [COUNT_W:0]   total;
    v = '{STATUS_INCOMPLETE, '0, '0};
    pos = frm.seen;
    if (held_error == STATUS_INCOMPLETE) begin
      if (frm.seen != COUNT_MAX) frm.seen++;
      if (!frm.head_done) begin
        if (pos < PREFIX_LEN && b != PREFIX_TEXT[31 - 8*pos -: 8]) frm.http_ok = 1'b0;
        if (frm.in_value) begin
          if (b == CHAR_CR) begin
            frm.in_value = 1'b0;
          end else begin
            if (frm.value_chars == 0 && b == CHAR_MINUS)
              frm.value_chars = DIGIT_W'(MAX_LENGTH_DIGITS + 1);
            if (frm.value_chars < MAX_LENGTH_DIGITS) begin
              if (!frm.value_end && b >= CHAR_ZERO && b <= CHAR_NINE)
                frm.value = LEN_W'(frm.value * 10 + (b - CHAR_ZERO));
              else
                frm.value_end = 1'b1;
            end
            if (frm.value_chars <= MAX_LENGTH_DIGITS) frm.value_chars++;
          end
        end
        // only the first label in the header counts
        if (frm.label_pos < LABEL_LEN) begin
          if (b == LABEL_TEXT[127 - 8*frm.label_pos -: 8])
            frm.label_pos++;
          else
            frm.label_pos = (b == CHAR_C) ? LABEL_W'(1) : '0;
          if (frm.label_pos == LABEL_LEN) frm.in_value = 1'b1;
        end
        if (b == TERM_TEXT[31 - 8*frm.crlf_pos -: 8]) begin
          if (frm.crlf_pos == 2'd3) begin
            frm.head_done = 1'b1;
            frm.head_len  = frm.seen;
            frm.crlf_pos  = '0;
          end else begin
            frm.crlf_pos++;
          end
        end else begin
          frm.crlf_pos = (b == CHAR_CR) ? 2'd1 : 2'd0;
        end
      end
      if (frm.head_done && frm.seen >= MIN_MESSAGE_BYTES) begin
        total = frm.head_len + frm.value;
        if (!frm.http_ok) begin
          held_error = STATUS_NOT_HTTP;
        end else if (frm.value_chars > MAX_LENGTH_DIGITS || total > capacity) begin
          held_error = STATUS_BAD_LENGTH;
        end else if (total <= frm.seen) begin
          v = '{STATUS_COMPLETE, frm.head_len, frm.value};
          frm = fresh_frame();
        end
      end
    end
    if (held_error != STATUS_INCOMPLETE) v.st = held_error;
    return v;
  endfunction

  task automatic report(input string field, input logic [COUNT_W-1:0] exp_val,
                        input logic [COUNT_W-1:0] act_val);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, act_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frm        = fresh_frame();
      held_error = STATUS_INCOMPLETE;
      capacity   = COUNT_W'(BUFSIZE_RESET);
      verdicts_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      if (in_valid && in_ready) begin
        verdicts_due.push_back(frame_verdict(data_byte));
        bytes_seen++;
      end
      if (out_valid && out_ready) begin
        if (status == STATUS_COMPLETE)
          messages_framed++;
        else if (status == STATUS_NOT_HTTP || status == STATUS_BAD_LENGTH)
          error_verdicts++;
        if (verdicts_due.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d", $time, status);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (status !== want.st) report("status", want.st, status);
          if (header_length !== want.hlen) report("header_length", want.hlen, header_length);
          if (body_length !== want.blen) report("body_length", want.blen, body_length);
        end
      end
    end
    pending <= verdicts_due.size();
  end

endmodule

// ----- bench/tb.sv -----
// Testbench top for http_response_framer: builds response byte streams,
// writes buffer_size and applies back-pressure; hrf_checker does the checking.
// Depends on hrf_pkg, hrf_checker and the framer RTL.
module tb;
  import hrf_pkg::*;

  typedef enum int {
    END_NOT_HTTP,
    END_MINUS,
    END_LONG_VALUE,
    END_OVER_BUFFER,
    END_BOTH
  } ending_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [7:0]         data_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [COUNT_W-1:0] header_length;
  logic [LEN_W-1:0]   body_length;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data  = '0;

  int mismatches, pending, bytes_seen, messages_framed, error_verdicts;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int cfg_writes     = 0;
  int sent;
  int k;
  int unsigned n;

  logic [COUNT_W-1:0] buffer_now = COUNT_W'(BUFSIZE_RESET);
  logic [7:0]         frame_bytes[$];
  ending_t            ending;

  always #10 clk = ~clk;

  http_response_framer i_dut (.*);

  hrf_checker i_checker (.*);

  always @(posedge clk) out_ready <= !rst && ($urandom_range(0, 99) >= sink_stall_pct);

  initial begin
    #20_000_000;
    $display("[http_response_framer] ERROR");
    $finish;
  end

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endtask

  task automatic add_random(input int unsigned cnt, input int unsigned lo, input int unsigned hi);
    repeat (cnt) frame_bytes.push_back(8'($urandom_range(lo, hi)));
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) begin
      while ($urandom_range(0, 99) < src_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid  <= 1'b1;
      data_byte <= frame_bytes[i];
      do @(posedge clk); while (!in_ready);
    end
    frame_bytes.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_buffer_size(input logic [COUNT_W-1:0] size);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    buffer_now = size;
    cfg_writes++;
  endtask

  task automatic add_header_line();
    case ($urandom_range(0, 3))
      0: add_text("Content-Type: text/plain");
      1: add_text("Content-Lengths: 7");
      2: begin
        add_text("X-Id: ");
        add_random($urandom_range(0, 10), 32, 126);
      end
      default: add_text("Via: proxy\r");
    endcase
    add_text("\r\n");
  endtask

  // Well-formed response whose header plus declared body fits in cap.
  task automatic build_message(input int unsigned cap);
    int unsigned v, want, tries, len;
    int          form;
    string       txt;
    tries = 0;
    do begin
      frame_bytes.delete();
      v = 0;
      add_text("HTTP");
      add_random($urandom_range(0, 12), 32, 126);
      add_text("\r\n");
      repeat ($urandom_range(0, 2)) add_header_line();
      if ($urandom_range(0, 3) != 0) begin
        want = ($urandom_range(0, 7) == 0) ? $urandom_range(31, 300) : $urandom_range(0, 30);
        txt  = $sformatf("%0d", want);
        form = $urandom_range(0, 9);
        v    = (form < 2) ? 0 : want;
        len  = txt.len();
        add_text("Content-Length: ");
        if (form == 1) add_text("x");
        if (form >= 2) begin
          len = $urandom_range(txt.len(), MAX_LENGTH_DIGITS);
          add_random(len - txt.len(), CHAR_ZERO, CHAR_ZERO);
        end
        if (form != 0) add_text(txt);
        if (form >= 2)
          repeat ($urandom_range(0, MAX_LENGTH_DIGITS - len))
            frame_bytes.push_back(($urandom_range(0, 3) == 0) ? CHAR_MINUS
                                                              : 8'($urandom_range(97, 122)));
        add_text("\r\n");
        repeat ($urandom_range(0, 1)) add_header_line();
      end
      add_text("\r\n");
      tries++;
    end while (frame_bytes.size() + v > cap && tries < 40);
    if (frame_bytes.size() + v > cap) begin
      frame_bytes.delete();
      v = 0;
      add_text("HTTP\r\n\r\n");
    end
    add_random(v, 0, 255);
    while (frame_bytes.size() < MIN_MESSAGE_BYTES) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed cases at the reset buffer size
    add_text("HTTP/1.1 200 OK\r\nContent-Length: 5\r\n\r\nhello");
    send_frame();
    add_text("HTTP\r\n\r\n");
    add_random(12, 0, 0);
    send_frame();
    add_text("HTTP/1.0 200\r\nContent-Length: 0020ab\r\nX: Content-Length: 9\r\n\r\n");
    add_text("Content-Length: 7\r\n\r");
    send_frame();
    add_text("HTTP\r\nContent-Length: x\r\n\r\n");
    send_frame();
    add_text("HTTP\r\nContent-Length: \r\n\r\n");
    send_frame();
    add_text("HTTP\r\r\n\r\n");
    add_random(12, 255, 255);
    send_frame();
    add_text("HTTP\r\nContent-Length: 100\r\n\r\n");
    add_random(100, 0, 255);
    send_frame();

    // exact fit: 28 header bytes plus 12 body bytes
    write_buffer_size(40);
    add_text("HTTP\r\nContent-Length: 12\r\n\r\n");
    add_random(12, 0, 255);
    send_frame();

    write_buffer_size(MIN_MESSAGE_BYTES);
    repeat (3) begin
      build_message(buffer_now);
      send_frame();
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_buffer_size(COUNT_W'(BUFSIZE_RESET));
        1: write_buffer_size(21'd1048576);
        2: write_buffer_size(COUNT_W'($urandom_range(400, 8192)));
        default: write_buffer_size(COUNT_W'($urandom_range(400, 1048576)));
      endcase
      src_idle_pct   = (p == 1) ? 78 : (p == 3) ? 27 : 0;
      sink_stall_pct = (p == 2) ? 78 : (p == 3) ? 27 : 0;
      sent = 0;
      while (sent < 40) begin
        build_message(buffer_now);
        sent += frame_bytes.size();
        send_frame();
        if ($urandom_range(0, 5) == 0) wait_drained();
      end
    end

    // errors are sticky, so the run ends on one broken message
    ending = ending_t'($urandom_range(0, 4));
    case (ending)
      END_NOT_HTTP: build_message(buffer_now);
      END_LONG_VALUE: begin
        add_text("HTTP\r\nContent-Length: ");
        add_random($urandom_range(MAX_LENGTH_DIGITS + 1, 10), CHAR_ZERO, CHAR_NINE);
        add_text("\r\n\r\n");
      end
      END_OVER_BUFFER: begin
        n = $urandom_range(20, 500);
        add_text($sformatf("HTTP\r\nContent-Length: %0d\r\n\r\n", n));
        write_buffer_size(COUNT_W'(frame_bytes.size() + n - 1));
        add_random(5, 0, 255);
      end
      default: begin
        add_text("HTTP\r\nContent-Length: -");
        add_random($urandom_range(0, 4), CHAR_ZERO, CHAR_NINE);
        add_text("\r\n\r\n");
      end
    endcase
    if (ending == END_NOT_HTTP || ending == END_BOTH) begin
      k = $urandom_range(0, PREFIX_LEN - 1);
      frame_bytes[k] = frame_bytes[k] ^ 8'($urandom_range(1, 255));
    end
    add_random(30, 0, 255);
    send_frame();
    write_buffer_size(COUNT_W'(BUFSIZE_RESET));
    add_random(10, 0, 255);
    send_frame();

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Run covered %0d bytes, %0d framed responses, %0d error verdicts, %0d size writes.",
             bytes_seen, messages_framed, error_verdicts, cfg_writes);
    $display("Closing broken message: %s", ending.name());
    if (mismatches == 0 && pending == 0)
      $display("[http_response_framer] OK");
    else
      $display("[http_response_framer] ERROR");
    $finish;
  end

endmodule
